// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/pcst_pkg.sv -----
// ---------------------------------------------------------------------------
// Call stack tracker package
// Shared constants, register indexes, controller/datapath structs and return-value helpers.
// ---------------------------------------------------------------------------
package pcst_pkg;
  localparam int unsigned NumCpusDef    = 8;
  localparam int unsigned StackDepthDef = 32;
  localparam int unsigned FuncCountDef  = 1024;
  localparam logic [63:0] ErrnoLow      = 64'hFFFF_FFFF_FFFF_F001;

  localparam logic [0:0] RegTracing = 1'b0;
  localparam logic [0:0] RegPid     = 1'b1;

  typedef struct packed {
    logic init_step;
    logic push;
    logic pop;
    logic copy_step;
    logic emit_step;
    logic clear;
  } pcst_cmd_t;

  typedef struct packed {
    logic init_last;
    logic push_ok;
    logic need_snap;
    logic pop_ok;
    logic pop_done;
    logic step_last;
  } pcst_sts_t;

  function automatic logic is_err_val(logic [63:0] raw, logic cant_fail, logic sext,
                                      logic ret_ptr);
    logic [63:0] v;
    v = sext ? {{32{raw[31]}}, raw[31:0]} : raw;
    is_err_val = !cant_fail && ((v >= ErrnoLow) || (ret_ptr && (v == 64'd0)));
  endfunction

  function automatic logic [63:0] ext_val(logic [63:0] raw, logic cant_fail, logic sext);
    ext_val = (!cant_fail && sext) ? {{32{raw[31]}}, raw[31:0]} : raw;
  endfunction
endpackage

// ----- hw/rtl/pcst_ctrl.sv -----
// ---------------------------------------------------------------------------
// Call stack tracker controller
// Sequences event handling, snapshot copies and record emission.
// ---------------------------------------------------------------------------
module pcst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ev_valid_i,
  input  logic              ev_action_i,
  output logic              ev_stall_o,
  input  pcst_pkg::pcst_sts_t sts_i,
  output pcst_pkg::pcst_cmd_t cmd_o,
  output logic              out_valid_o,
  input  logic              out_stall_i
);
  import pcst_pkg::*;

  typedef enum logic [2:0] {StInit, StIdle, StEval, StCopy, StEmit, StClear} state_e;
  state_e state_q, state_d;
  logic   act_q;

  assign ev_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StEmit);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StInit: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_last) state_d = StIdle;
      end
      StIdle: begin
        if (ev_valid_i) state_d = StEval;
      end
      StEval: begin
        if (act_q) begin
          if (sts_i.push_ok && sts_i.need_snap) state_d = StCopy;
          else begin
            cmd_o.push = sts_i.push_ok;
            state_d = StIdle;
          end
        end else begin
          cmd_o.pop = sts_i.pop_ok;
          state_d = (sts_i.pop_ok && sts_i.pop_done) ? StEmit : StIdle;
        end
      end
      StCopy: begin
        cmd_o.copy_step = 1'b1;
        if (sts_i.step_last) begin
          cmd_o.push = 1'b1;
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (!out_stall_i) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.step_last) state_d = StClear;
        end
      end
      StClear: begin
        cmd_o.clear = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      act_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle && ev_valid_i) act_q <= ev_action_i;
    end
  end
endmodule

// ----- hw/rtl/pcst_dp.sv -----
// ---------------------------------------------------------------------------
// Call stack tracker datapath
// Frame and snapshot memories, per-processor counters and output registers.
// ---------------------------------------------------------------------------
module pcst_dp #(
  parameter int unsigned NumCpus    = pcst_pkg::NumCpusDef,
  parameter int unsigned StackDepth = pcst_pkg::StackDepthDef,
  parameter int unsigned FuncCount  = pcst_pkg::FuncCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ev_take_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [22:0]         cfg_data_i,
  input  logic                action_i,
  input  logic [2:0]          cpu_i,
  input  logic [22:0]         pid_i,
  input  logic [9:0]          func_id_i,
  input  logic                func_is_entry_i,
  input  logic                func_cant_fail_i,
  input  logic                func_needs_sign_ext_i,
  input  logic                func_ret_ptr_i,
  input  logic [63:0]         ret_value_i,
  input  pcst_pkg::pcst_cmd_t cmd_i,
  output pcst_pkg::pcst_sts_t sts_o,
  output logic [2:0]          out_cpu_o,
  output logic [4:0]          level_o,
  output logic [9:0]          level_func_id_o,
  output logic [63:0]         level_result_o,
  output logic [9:0]          saved_func_id_o,
  output logic [63:0]         saved_result_o,
  output logic                stack_is_error_o,
  output logic [5:0]          error_max_depth_o,
  output logic [5:0]          snapshot_depth_o,
  output logic [5:0]          snapshot_max_o,
  output logic                last_o
);
  import pcst_pkg::*;

  localparam int unsigned CW = (NumCpus > 1) ? $clog2(NumCpus) : 1;
  localparam int unsigned LW = $clog2(StackDepth);
  localparam int unsigned DW = $clog2(StackDepth + 2);
  localparam int unsigned AW = CW + LW;
  localparam int unsigned Words = 1 << AW;

  logic [9:0]  fid_mem [Words];
  logic [63:0] fres_mem[Words];
  logic [9:0]  sid_mem [Words];
  logic [63:0] sres_mem[Words];

  logic [DW-1:0] cur_q [NumCpus];
  logic [DW-1:0] pmax_q[NumCpus];
  logic [DW-1:0] sd_q  [NumCpus];
  logic [DW-1:0] smax_q[NumCpus];
  logic [NumCpus-1:0] err_q;

  logic        tracing_q;
  logic [22:0] pidf_q;

  logic        entry_q, err_ev_q, ok_q;
  logic [CW-1:0] c_q;
  logic [9:0]  id_q;
  logic [63:0] res_q;
  logic [9:0]  top_id_q;
  logic [LW-1:0] k_q;
  logic [9:0]  rd_fid_q, rd_sid_q;
  logic [63:0] rd_fres_q, rd_sres_q;
  logic        pre_q;
  logic [AW-1:0] init_q;
  logic [AW-1:0] top_addr;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] k_nx;
  logic        pop_match;

  logic [DW-1:0] d_cur;
  assign d_cur    = cur_q[c_q];
  assign top_addr = {c_q, LW'(d_cur - DW'(1))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracing_q <= 1'b0;
      pidf_q    <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegTracing) tracing_q <= cfg_data_i[0];
      else pidf_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_take_i) begin
      entry_q  <= func_is_entry_i;
      c_q      <= CW'(cpu_i);
      id_q     <= func_id_i;
      res_q    <= ext_val(ret_value_i, func_cant_fail_i, func_needs_sign_ext_i);
      err_ev_q <= is_err_val(ret_value_i, func_cant_fail_i, func_needs_sign_ext_i,
                             func_ret_ptr_i);
      ok_q     <= tracing_q && (pidf_q == '0 || pid_i == pidf_q)
                  && (32'(cpu_i) < NumCpus) && (32'(func_id_i) < FuncCount);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_take_i)
      top_id_q <= fid_mem[{CW'(cpu_i), LW'(cur_q[CW'(cpu_i)] - DW'(1))}];
  end

  assign sts_o.init_last = (init_q == AW'(Words - 1));
  assign sts_o.push_ok   = ok_q && !(d_cur == '0 && !entry_q) && (d_cur < DW'(StackDepth));
  assign sts_o.need_snap = (d_cur != pmax_q[c_q]) && err_q[c_q];
  assign sts_o.pop_ok    = ok_q && (d_cur != '0) && (d_cur <= DW'(StackDepth));
  assign sts_o.pop_done  = (top_id_q == id_q) && (d_cur == DW'(1));
  assign sts_o.step_last = pre_q && (k_q == LW'(StackDepth - 1));

  assign k_nx      = (cmd_i.copy_step || cmd_i.emit_step) ? k_q + LW'(1) : k_q;
  assign rd_addr   = {c_q, k_nx};
  assign pop_match = cmd_i.pop && (top_id_q == id_q);

  // Read port runs one slot ahead of the step counter.
  always_ff @(posedge clk_i) begin
    rd_fid_q  <= fid_mem[rd_addr];
    rd_fres_q <= (pop_match && (rd_addr == top_addr)) ? res_q : fres_mem[rd_addr];
    rd_sid_q  <= sid_mem[rd_addr];
    rd_sres_q <= sres_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step) begin
      fid_mem[init_q]  <= '0;
      fres_mem[init_q] <= '0;
      sid_mem[init_q]  <= '0;
      sres_mem[init_q] <= '0;
    end
    if (cmd_i.push) fid_mem[{c_q, LW'(d_cur)}] <= id_q;
    if (pop_match) fres_mem[top_addr] <= res_q;
    if (cmd_i.copy_step) begin
      sid_mem[{c_q, k_q}]  <= rd_fid_q;
      sres_mem[{c_q, k_q}] <= rd_fres_q;
    end
  end

  integer i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q   <= '0;
      k_q     <= '0;
      pre_q   <= 1'b0;
      init_q  <= '0;
      for (i = 0; i < NumCpus; i++) begin
        cur_q[i] <= '0; pmax_q[i] <= '0; sd_q[i] <= '0; smax_q[i] <= '0;
      end
    end else begin
      pre_q <= 1'b1;
      if (cmd_i.init_step) init_q <= init_q + AW'(1);
      if (ev_take_i) begin
        k_q   <= '0;
        pre_q <= 1'b0;
      end else if (cmd_i.copy_step || cmd_i.emit_step) begin
        k_q <= k_q + LW'(1);
      end
      if (cmd_i.push) begin
        err_q[c_q]  <= 1'b0;
        cur_q[c_q]  <= d_cur + DW'(1);
        pmax_q[c_q] <= d_cur + DW'(1);
        if (cmd_i.copy_step) begin
          sd_q[c_q]   <= d_cur + DW'(1);
          smax_q[c_q] <= pmax_q[c_q];
        end
      end
      if (cmd_i.pop) begin
        if (!pop_match) begin
          cur_q[c_q] <= '0; pmax_q[c_q] <= '0; err_q[c_q] <= 1'b0;
        end else begin
          cur_q[c_q] <= d_cur - DW'(1);
          if (err_ev_q && !err_q[c_q]) begin
            err_q[c_q]  <= 1'b1;
            pmax_q[c_q] <= d_cur;
          end
        end
      end
      if (cmd_i.clear) begin
        err_q[c_q] <= 1'b0; sd_q[c_q] <= '0; smax_q[c_q] <= '0;
        cur_q[c_q] <= '0; pmax_q[c_q] <= '0;
      end
    end
  end

  assign out_cpu_o         = 3'(c_q);
  assign level_o           = 5'(k_q);
  assign level_func_id_o   = rd_fid_q;
  assign level_result_o    = rd_fres_q;
  assign saved_func_id_o   = rd_sid_q;
  assign saved_result_o    = rd_sres_q;
  assign stack_is_error_o  = err_q[c_q];
  assign error_max_depth_o = 6'(pmax_q[c_q]);
  assign snapshot_depth_o  = 6'(sd_q[c_q]);
  assign snapshot_max_o    = 6'(smax_q[c_q]);
  assign last_o            = (k_q == LW'(StackDepth - 1));
endmodule

// ----- hw/rtl/per_cpu_call_stack_tracker.sv -----
// ---------------------------------------------------------------------------
// Per-processor call stack tracker
// Tracks function entry/exit per processor and emits completed call records.
// ---------------------------------------------------------------------------
// Events arrive on the evt channel (valid/stall) and are accepted when
// evt_valid_i is high and evt_stall_o is low. Configuration writes use the
// cfg channel (valid/ready); cfg_ready_o is high only while no event is in work.
// In the controller an event is first captured while the top frame is read,
// then evaluated and the stack updated. A push that must save an unwound
// error path first copies the processor's whole stack into the snapshot
// memory, one level per cycle.
// An exit that closes the outermost call emits STACK_DEPTH results on the
// rec channel, one per cycle while rec_stall_i is low, then a clear state
// resets the processor's counters. While results are stalled the block
// holds the current level and accepts no event.
// Reset clears the state, counters and configuration registers, then a
// clearing pass zeroes the frame and snapshot memories, 2^(max(1,
// clog2(NUM_CPUS)) + clog2(STACK_DEPTH)) words each (256 by default), one
// word per cycle; events and configuration wait until it ends.
// ---------------------------------------------------------------------------
module per_cpu_call_stack_tracker #(
  parameter int unsigned NumCpus    = pcst_pkg::NumCpusDef,
  parameter int unsigned StackDepth = pcst_pkg::StackDepthDef,
  parameter int unsigned FuncCount  = pcst_pkg::FuncCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [22:0] cfg_data_i,
  input  logic        evt_valid_i,
  output logic        evt_stall_o,
  input  logic        action_i,
  input  logic [2:0]  cpu_i,
  input  logic [22:0] pid_i,
  input  logic [9:0]  func_id_i,
  input  logic        func_is_entry_i,
  input  logic        func_cant_fail_i,
  input  logic        func_needs_sign_ext_i,
  input  logic        func_ret_ptr_i,
  input  logic [63:0] ret_value_i,
  output logic        rec_valid_o,
  input  logic        rec_stall_i,
  output logic [2:0]  out_cpu_o,
  output logic [4:0]  level_o,
  output logic [9:0]  level_func_id_o,
  output logic [63:0] level_result_o,
  output logic [9:0]  saved_func_id_o,
  output logic [63:0] saved_result_o,
  output logic        stack_is_error_o,
  output logic [5:0]  error_max_depth_o,
  output logic [5:0]  snapshot_depth_o,
  output logic [5:0]  snapshot_max_o,
  output logic        last_o
);
  import pcst_pkg::*;

  pcst_cmd_t cmd;
  pcst_sts_t sts;
  logic      take;

  assign cfg_ready_o = !evt_stall_o;
  assign take        = evt_valid_i && !evt_stall_o;

  pcst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (evt_valid_i),
    .ev_action_i (action_i),
    .ev_stall_o  (evt_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .out_valid_o (rec_valid_o),
    .out_stall_i (rec_stall_i)
  );

  pcst_dp #(
    .NumCpus    (NumCpus),
    .StackDepth (StackDepth),
    .FuncCount  (FuncCount)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .ev_take_i             (take),
    .cfg_we_i              (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i             (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .action_i              (action_i),
    .cpu_i                 (cpu_i),
    .pid_i                 (pid_i),
    .func_id_i             (func_id_i),
    .func_is_entry_i       (func_is_entry_i),
    .func_cant_fail_i      (func_cant_fail_i),
    .func_needs_sign_ext_i (func_needs_sign_ext_i),
    .func_ret_ptr_i        (func_ret_ptr_i),
    .ret_value_i           (ret_value_i),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .out_cpu_o             (out_cpu_o),
    .level_o               (level_o),
    .level_func_id_o       (level_func_id_o),
    .level_result_o        (level_result_o),
    .saved_func_id_o       (saved_func_id_o),
    .saved_result_o        (saved_result_o),
    .stack_is_error_o      (stack_is_error_o),
    .error_max_depth_o     (error_max_depth_o),
    .snapshot_depth_o      (snapshot_depth_o),
    .snapshot_max_o        (snapshot_max_o),
    .last_o                (last_o)
  );
endmodule

// ----- hw/rtl/pcst_checker.sv -----
// ---------------------------------------------------------------------------
// Call stack tracker checker
// Port-level checks on record emission and the event handshake.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module pcst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       evt_stall_o,
  input logic       rec_valid_o,
  input logic       rec_stall_i,
  input logic [4:0] level_o,
  input logic       last_o
);
  `ASSERT_IMPL(a_no_evt_during_rec, clk_i, rst_ni, rec_valid_o, evt_stall_o)
  `ASSERT_NEXT(a_level_steps, clk_i, rst_ni, rec_valid_o && !rec_stall_i && !last_o,
    rec_valid_o && level_o == $past(level_o) + 5'd1)
  `ASSERT_NEXT(a_rec_holds, clk_i, rst_ni, rec_valid_o && rec_stall_i,
    rec_valid_o && $stable(level_o))
  `ASSERT_NEXT(a_last_ends, clk_i, rst_ni, rec_valid_o && !rec_stall_i && last_o,
    !rec_valid_o)
endmodule

bind per_cpu_call_stack_tracker pcst_checker u_pcst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .evt_stall_o (evt_stall_o),
  .rec_valid_o (rec_valid_o),
  .rec_stall_i (rec_stall_i),
  .level_o     (level_o),
  .last_o      (last_o)
);

// ----- bench/testbench.sv -----
// ---------------------------------------------------------------------------
// Call stack tracker testbench
// Drives function entry and exit events into the tracker, predicts every
// emitted record level in a behavioral model of the per-processor stacks,
// and compares each level field by field under random output stalls and random gaps between events.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcst_pkg::*;

  localparam int Cpus = 8;
  localparam int Depth = 32;
  localparam int CycleLimit = 600000;

  typedef struct {
    bit        action;
    bit [2:0]  cpu;
    bit [22:0] pid;
    bit [9:0]  id;
    bit        entry;
    bit        cant_fail;
    bit        sext;
    bit        ret_ptr;
    bit [63:0] ret;
  } call_evt_t;

  typedef struct {
    bit [2:0]  cpu;
    bit [4:0]  level;
    bit [9:0]  fid;
    bit [63:0] res;
    bit [9:0]  sfid;
    bit [63:0] sres;
    bit        err;
    bit [5:0]  pmax;
    bit [5:0]  sdep;
    bit [5:0]  smax;
    bit        last;
  } level_rec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [22:0] cfg_data_i;
  logic        evt_valid_i;
  logic        evt_stall_o;
  logic        action_i;
  logic [2:0]  cpu_i;
  logic [22:0] pid_i;
  logic [9:0]  func_id_i;
  logic        func_is_entry_i;
  logic        func_cant_fail_i;
  logic        func_needs_sign_ext_i;
  logic        func_ret_ptr_i;
  logic [63:0] ret_value_i;
  logic        rec_valid_o;
  logic        rec_stall_i;
  logic [2:0]  out_cpu_o;
  logic [4:0]  level_o;
  logic [9:0]  level_func_id_o;
  logic [63:0] level_result_o;
  logic [9:0]  saved_func_id_o;
  logic [63:0] saved_result_o;
  logic        stack_is_error_o;
  logic [5:0]  error_max_depth_o;
  logic [5:0]  snapshot_depth_o;
  logic [5:0]  snapshot_max_o;
  logic        last_o;

  per_cpu_call_stack_tracker dut (.*);

  bit [9:0]  frame_id[Cpus][Depth];
  bit [63:0] frame_res[Cpus][Depth];
  bit [9:0]  snap_id[Cpus][Depth];
  bit [63:0] snap_res[Cpus][Depth];
  int        cur_depth[Cpus];
  int        path_max[Cpus];
  bit        err_flag[Cpus];
  int        snap_depth[Cpus];
  int        snap_max[Cpus];
  bit        trace_on;
  bit [22:0] pid_sel;

  level_rec_t pending_levels[$];
  int        errors;
  int        cycles;
  bit        evt_on;
  bit        quiet;
  bit        long_req;
  int        hold_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    if (errors < 40) begin
      $display("ERROR @%0t: %s got %0h expected %0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report(what, got, want);
    end
  endtask

  function automatic void apply_event(call_evt_t e);
    int c;
    int d;
    bit [63:0] v;
    bit bad;
    level_rec_t r;
    if (!trace_on) return;
    if (pid_sel != 0 && e.pid != pid_sel) return;
    c = e.cpu;
    d = cur_depth[c];
    if (e.action) begin
      if (d == 0 && !e.entry) return;
      if (d >= Depth) return;
      if (cur_depth[c] != path_max[c] && err_flag[c]) begin
        snap_id[c] = frame_id[c];
        snap_res[c] = frame_res[c];
        snap_depth[c] = d + 1;
        snap_max[c] = path_max[c];
      end
      frame_id[c][d] = e.id;
      err_flag[c] = 1'b0;
      cur_depth[c] = d + 1;
      path_max[c] = d + 1;
      return;
    end
    if (d == 0) return;
    d--;
    if (frame_id[c][d] != e.id) begin
      cur_depth[c] = 0;
      path_max[c] = 0;
      err_flag[c] = 1'b0;
      return;
    end
    v = (!e.cant_fail && e.sext) ? {{32{e.ret[31]}}, e.ret[31:0]} : e.ret;
    bad = !e.cant_fail && (v >= ErrnoLow || (e.ret_ptr && v == 64'd0));
    frame_res[c][d] = v;
    if (bad && !err_flag[c]) begin
      err_flag[c] = 1'b1;
      path_max[c] = d + 1;
    end
    cur_depth[c] = d;
    if (d != 0) return;
    for (int k = 0; k < Depth; k++) begin
      r.cpu = 3'(c);
      r.level = 5'(k);
      r.fid = frame_id[c][k];
      r.res = frame_res[c][k];
      r.sfid = snap_id[c][k];
      r.sres = snap_res[c][k];
      r.err = err_flag[c];
      r.pmax = 6'(path_max[c]);
      r.sdep = 6'(snap_depth[c]);
      r.smax = 6'(snap_max[c]);
      r.last = (k == Depth - 1);
      pending_levels.push_back(r);
    end
    err_flag[c] = 1'b0;
    snap_depth[c] = 0;
    snap_max[c] = 0;
    cur_depth[c] = 0;
    path_max[c] = 0;
  endfunction

  always @(posedge clk_i) begin
    level_rec_t w;
    if (rst_ni && rec_valid_o && !rec_stall_i) begin
      if (pending_levels.size() == 0) begin
        report("unexpected record level", 64'(level_o), 64'd0);
      end else begin
        w = pending_levels.pop_front();
        check_field("out_cpu", 64'(out_cpu_o), 64'(w.cpu));
        check_field("level", 64'(level_o), 64'(w.level));
        check_field("level_func_id", 64'(level_func_id_o), 64'(w.fid));
        check_field("level_result", level_result_o, w.res);
        check_field("saved_func_id", 64'(saved_func_id_o), 64'(w.sfid));
        check_field("saved_result", saved_result_o, w.sres);
        check_field("stack_is_error", 64'(stack_is_error_o), 64'(w.err));
        check_field("error_max_depth", 64'(error_max_depth_o), 64'(w.pmax));
        check_field("snapshot_depth", 64'(snapshot_depth_o), 64'(w.sdep));
        check_field("snapshot_max", 64'(snapshot_max_o), 64'(w.smax));
        check_field("last", 64'(last_o), 64'(w.last));
      end
    end
  end

  initial begin
    rec_stall_i = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_req) begin
        long_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        rec_stall_i <= 1'b1;
        hold_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rec_stall_i <= 1'b1;
        hold_left = $urandom_range(0, 4);
      end else begin
        rec_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_event(call_evt_t e);
    evt_valid_i <= 1'b1;
    evt_on = 1'b1;
    action_i <= e.action;
    cpu_i <= e.cpu;
    pid_i <= e.pid;
    func_id_i <= e.id;
    func_is_entry_i <= e.entry;
    func_cant_fail_i <= e.cant_fail;
    func_needs_sign_ext_i <= e.sext;
    func_ret_ptr_i <= e.ret_ptr;
    ret_value_i <= e.ret;
    do @(posedge clk_i); while (evt_stall_o);
    apply_event(e);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      evt_valid_i <= 1'b0;
      evt_on = 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    if (evt_on) begin
      evt_valid_i <= 1'b0;
      evt_on = 1'b0;
    end
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [22:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegTracing) trace_on = value[0];
    else pid_sel = value;
  endtask

  function automatic bit [22:0] good_pid();
    return (pid_sel != 0) ? pid_sel : 23'($urandom);
  endfunction

  function automatic call_evt_t mk(bit act, int cpu, int id, bit entry, bit cf, bit sx,
                                   bit ptr, bit [63:0] ret);
    call_evt_t e;
    e.action = act;
    e.cpu = 3'(cpu);
    e.pid = good_pid();
    e.id = 10'(id);
    e.entry = entry;
    e.cant_fail = cf;
    e.sext = sx;
    e.ret_ptr = ptr;
    e.ret = ret;
    return e;
  endfunction

  function automatic bit [63:0] pick_ret();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return ErrnoLow + 64'($urandom_range(0, 4094));
      2: return ErrnoLow - 64'd1;
      3: return {32'($urandom), 32'hFFFF_F000 | 32'($urandom_range(0, 4095))};
      4: return {32'($urandom), 32'($urandom)};
      default: return 64'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic call_evt_t pick_event();
    call_evt_t e;
    int c;
    int r;
    c = $urandom_range(0, Cpus - 1);
    r = $urandom_range(0, 99);
    e = mk(1'($urandom_range(0, 1)), c, $urandom_range(0, 1023), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
           pick_ret());
    if (r < 8) begin
      e.pid = 23'($urandom);
    end else if (cur_depth[c] == 0 || (r < 50 && cur_depth[c] < Depth)) begin
      e.action = 1'b1;
      e.entry = (r % 10 != 0);
      e.cant_fail = ($urandom_range(0, 3) == 0);
    end else begin
      e.action = 1'b0;
      if (r < 95) e.id = frame_id[c][cur_depth[c] - 1];
      e.cant_fail = ($urandom_range(0, 4) == 0);
    end
    return e;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_event(pick_event());
  endtask

  task automatic test_tracing_off;
    for (int i = 0; i < 6; i++) send_event(mk(i % 2 == 0, i, 5, 1, 0, 0, 0, 64'd1));
    send_event(mk(0, 5, 5, 1, 0, 0, 0, 64'd1));
    drain();
  endtask

  task automatic test_directed;
    write_reg(RegTracing, 23'd1);
    write_reg(RegPid, 23'd0);
    send_event(mk(1, 0, 7, 0, 0, 0, 0, 0));
    send_event(mk(0, 0, 7, 0, 0, 0, 0, 0));
    send_event(mk(1, 0, 1023, 1, 0, 0, 0, 0));
    send_event(mk(1, 0, 0, 0, 0, 0, 0, 0));
    send_event(mk(0, 0, 0, 0, 0, 0, 1, 64'd0));
    send_event(mk(0, 0, 1023, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_F000));
    send_event(mk(1, 1, 10, 1, 0, 0, 0, 0));
    send_event(mk(1, 1, 11, 0, 0, 0, 0, 0));
    send_event(mk(0, 1, 11, 0, 0, 1, 0, 64'h1234_5678_FFFF_F001));
    send_event(mk(1, 1, 12, 0, 0, 0, 0, 0));
    send_event(mk(0, 1, 12, 0, 1, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF));
    send_event(mk(0, 1, 10, 0, 0, 1, 0, 64'h0000_0000_7FFF_FFFF));
    send_event(mk(1, 7, 20, 1, 0, 0, 0, 0));
    send_event(mk(1, 7, 21, 0, 0, 0, 0, 0));
    send_event(mk(0, 7, 99, 0, 0, 0, 0, 0));
    send_event(mk(0, 7, 20, 0, 0, 0, 0, 0));
    send_event(mk(1, 2, 30, 1, 0, 0, 0, 0));
    send_event(mk(0, 2, 30, 0, 0, 0, 0, ErrnoLow - 64'd1));
    drain();
  endtask

  task automatic test_full_stack;
    for (int i = 0; i <= Depth; i++) send_event(mk(1, 3, 100 + i, 1, 0, 0, 0, 0));
    for (int i = Depth - 1; i >= 0; i--) begin
      send_event(mk(0, 3, 100 + i, 0, 0, 0, i % 3 == 0, pick_ret()));
    end
    drain();
  endtask

  task automatic test_pid_filter;
    call_evt_t e;
    write_reg(RegPid, 23'd4194304);
    for (int i = 0; i < 100; i++) begin
      e = pick_event();
      if ($urandom_range(0, 9) == 0) e.pid = 23'($urandom);
      send_event(e);
    end
    write_reg(RegPid, 23'($urandom_range(1, 4194303)));
    run_random(60);
    write_reg(RegPid, 23'd0);
  endtask

  task automatic test_backpressure;
    long_req = 1'b1;
    run_random(60);
    drain();
  endtask

  task automatic test_random;
    run_random(60);
    write_reg(RegTracing, 23'd0);
    run_random(15);
    write_reg(RegTracing, 23'd1);
    quiet = 1'b1;
    run_random(100);
    drain();
  endtask

  initial begin
    errors = 0;
    trace_on = 1'b0;
    pid_sel = '0;
    evt_on = 1'b0;
    quiet = 1'b0;
    long_req = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i = '0;
    evt_valid_i = 1'b0;
    action_i = 1'b0;
    cpu_i = '0;
    pid_i = '0;
    func_id_i = '0;
    func_is_entry_i = 1'b0;
    func_cant_fail_i = 1'b0;
    func_needs_sign_ext_i = 1'b0;
    func_ret_ptr_i = 1'b0;
    ret_value_i = '0;
    for (int c = 0; c < Cpus; c++) begin
      cur_depth[c] = 0;
      path_max[c] = 0;
      err_flag[c] = 1'b0;
      snap_depth[c] = 0;
      snap_max[c] = 0;
      for (int k = 0; k < Depth; k++) begin
        frame_id[c][k] = '0;
        frame_res[c][k] = '0;
        snap_id[c][k] = '0;
        snap_res[c][k] = '0;
      end
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_tracing_off();
    test_directed();
    test_full_stack();
    test_pid_filter();
    test_backpressure();
    test_random();
    repeat (100) @(posedge clk_i);
    if (pending_levels.size() != 0) begin
      report("record levels never emitted", 64'd0, 64'(pending_levels.size()));
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pcst_pkg.sv
hw/rtl/pcst_ctrl.sv
hw/rtl/pcst_dp.sv
hw/rtl/per_cpu_call_stack_tracker.sv
hw/rtl/pcst_checker.sv
bench/testbench.sv
